FILE: rtl/plb_pkg.sv
`default_nettype none

package plb_pkg;

  // request codes
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam int POS_W  = 7;
  localparam int WORD_W = 32;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] elem_value;
  } plb_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] elem_out;
    logic [POS_W-1:0]  list_count;
    logic              is_empty;
    logic [1:0]        status;
  } plb_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic setup;
    logic move;
    logic finish;
    logic load_out;
  } plb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_ok;
    logic move_done;
    logic out_free;
  } plb_sts_t;

endpackage

`default_nettype wire

FILE: rtl/plb_ram.sv
`default_nettype none

module plb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/plb_ctrl.sv
`default_nettype none

module plb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output plb_pkg::plb_cmd_t      cmd,
  input  wire plb_pkg::plb_sts_t sts
);

  import plb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        state_nxt = sts.req_ok ? S_MOVE : S_DONE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (sts.move_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plb_dp.sv
`default_nettype none

module plb_dp #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plb_pkg::plb_cmd_t cmd,
  output plb_pkg::plb_sts_t      sts,
  input  wire plb_pkg::plb_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output plb_pkg::plb_rsp_t      out_data
);

  import plb_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int XW    = (ELEM_WIDTH > WORD_W) ? ELEM_WIDTH : WORD_W;

  plb_req_t              req_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         rd_addr_r;
  logic [CNT_W-1:0]      rd_left_r;
  logic                  pend_r;
  logic [AW-1:0]         pend_addr_r;
  logic                  first_r;
  logic [ELEM_WIDTH-1:0] res_r;
  logic [1:0]            st_r;
  logic                  out_valid_r;
  plb_rsp_t              out_r;

  logic [CMP_W-1:0]      pos_c, n_c;
  logic [1:0]            chk_st;
  logic                  is_ins;
  logic                  capture;
  logic                  issue;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [ELEM_WIDTH-1:0] ram_rdata;
  logic [XW-1:0]         val_ext;
  logic [XW-1:0]         res_ext;
  logic [ELEM_WIDTH-1:0] ins_val;

  assign pos_c  = CMP_W'(req_r.position);
  assign n_c    = CMP_W'(count_r);
  assign is_ins = (req_r.req_type == REQ_INSERT);

  // request check, full before position on insert
  always_comb begin
    chk_st = ST_OK;
    case (req_r.req_type)
      REQ_READ, REQ_REMOVE: begin
        if (n_c == '0) begin
          chk_st = ST_EMPTY;
        end else if (pos_c == '0 || pos_c > n_c) begin
          chk_st = ST_BADPOS;
        end
      end
      REQ_INSERT: begin
        if (n_c >= CMP_W'(DEPTH)) begin
          chk_st = ST_FULL;
        end else if (pos_c == '0 || pos_c > n_c + CMP_W'(1)) begin
          chk_st = ST_BADPOS;
        end
      end
      default: begin
        chk_st = ST_BADPOS;
      end
    endcase
  end

  assign val_ext = XW'(req_r.elem_value);
  assign ins_val = val_ext[ELEM_WIDTH-1:0];

  // shift engine: one read issued, one write or capture per cycle
  assign issue   = cmd.move && (rd_left_r != '0);
  assign capture = cmd.move && pend_r && first_r && !is_ins;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    if (cmd.move && pend_r && !capture) begin
      ram_we    = 1'b1;
      ram_waddr = is_ins ? pend_addr_r + AW'(1) : pend_addr_r - AW'(1);
    end else if (cmd.finish && is_ins) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r;
      ram_wdata = ins_val;
    end
  end

  plb_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish) begin
      case (req_r.req_type)
        REQ_INSERT: count_nxt = count_r + CNT_W'(1);
        REQ_REMOVE: count_nxt = count_r - CNT_W'(1);
        default:    count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.setup) begin
        pend_r <= 1'b0;
        if (chk_st == ST_OK) begin
          rd_left_r <= is_ins || req_r.req_type == REQ_REMOVE
                     ? CNT_W'(n_c - pos_c + CMP_W'(1)) : CNT_W'(1);
        end else begin
          rd_left_r <= '0;
        end
      end else if (cmd.move) begin
        pend_r <= issue;
        if (issue) begin
          rd_left_r <= rd_left_r - CNT_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
    if (cmd.setup) begin
      idx_r     <= AW'(pos_c - CMP_W'(1));
      rd_addr_r <= is_ins ? AW'(count_r - CNT_W'(1)) : AW'(pos_c - CMP_W'(1));
      first_r   <= 1'b1;
      res_r     <= '0;
      st_r      <= chk_st;
    end else if (cmd.move) begin
      if (issue) begin
        pend_addr_r <= rd_addr_r;
        rd_addr_r   <= is_ins ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
      end
      if (pend_r) begin
        first_r <= 1'b0;
      end
      if (capture) begin
        res_r <= ram_rdata;
      end
    end
    if (cmd.load_out) begin
      out_r.elem_out   <= res_ext[WORD_W-1:0];
      out_r.list_count <= POS_W'(count_r);
      out_r.is_empty   <= (count_r == '0);
      out_r.status     <= st_r;
    end
  end

  assign res_ext = XW'(res_r);

  assign sts.req_ok    = (chk_st == ST_OK);
  assign sts.move_done = (rd_left_r == '0) && !pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: rtl/positional_list_buffer_top.sv
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid/in_ready    plb_req_t: req_type, position, elem_value
// out_      output     out_valid/out_ready  plb_rsp_t: elem_out, list_count, is_empty, status
//
// item sequence: a rejected item goes idle, check, done; read, remove and insert go idle,
// check, move, final, done, with one entry moved per cycle through the memory's two ports
// rst_n is synchronous: count goes to zero, entry memory is not cleared
// the next item is taken while a finished result waits in the output register;
// a stalled out_ready holds the block only at the end of the following item

module positional_list_buffer_top #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plb_pkg::plb_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output plb_pkg::plb_rsp_t      out_data
);

  import plb_pkg::*;

  // command and status between sequencer and datapath
  plb_cmd_t cmd;
  plb_sts_t sts;

  // sequencer: idle, check, move entries, commit, hand off result
  plb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: request register, count, entry memory with shift engine,
  // output register
  plb_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/plb_list_checker.sv
`default_nettype none

module plb_list_checker #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire plb_pkg::plb_req_t in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire plb_pkg::plb_rsp_t out_data,
  output int                     error_total,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import plb_pkg::*;

  localparam logic [WORD_W-1:0] KEEP_MASK = (ELEM_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << ELEM_WIDTH) - 64'd1);

  logic [WORD_W-1:0] list_mem [DEPTH];
  int unsigned       list_len;
  plb_rsp_t          pending_rsp [$];
  int                mismatches;

  // applies one request to the shadow list, returns the response it should give
  function automatic plb_rsp_t apply_request(input plb_req_t r);
    plb_rsp_t    rsp;
    int unsigned slot;
    int          k;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_READ, REQ_REMOVE: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (r.position == 0 || r.position > list_len) begin
          rsp.status = ST_BADPOS;
        end else begin
          slot = r.position - 1;
          rsp.elem_out = list_mem[slot];
          if (r.req_type == REQ_REMOVE) begin
            for (k = slot; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
            list_len--;
          end
        end
      end
      REQ_INSERT: begin
        if (list_len >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (r.position == 0 || r.position > list_len + 1) begin
          rsp.status = ST_BADPOS;
        end else begin
          slot = r.position - 1;
          for (k = list_len; k > slot; k--) list_mem[k] = list_mem[k - 1];
          list_mem[slot] = r.elem_value & KEEP_MASK;
          list_len++;
        end
      end
      default: begin
        rsp.status = ST_BADPOS;
      end
    endcase
    rsp.list_count = POS_W'(list_len);
    rsp.is_empty   = (list_len == 0);
    return rsp;
  endfunction

  always @(posedge clk) begin : watch
    plb_rsp_t want;
    if (!rst_n) begin
      list_len = 0;
      pending_rsp.delete();
      mismatches = 0;
    end else begin
      // result first: it can never belong to the item taken at this same edge
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: elem_out %h count %0d empty %b status %0d",
                     $realtime, out_data.elem_out, out_data.list_count,
                     out_data.is_empty, out_data.status);
        end else begin
          want = pending_rsp.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: elem_out exp %h got %h, count exp %0d got %0d, ",
                        "empty exp %b got %b, status exp %0d got %0d"},
                       $realtime, want.elem_out, out_data.elem_out,
                       want.list_count, out_data.list_count,
                       want.is_empty, out_data.is_empty, want.status, out_data.status);
          end
        end
      end
      if (in_valid && in_ready) pending_rsp.push_back(apply_request(in_data));
    end
    outstanding <= pending_rsp.size();
    error_total <= mismatches;
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plb_pkg::*;

  localparam int         LIST_DEPTH   = 64;
  localparam int         ELEM_BITS    = 32;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;  // spare request code, answered as bad position
  localparam int         RANDOM_ITEMS = 400;
  localparam int         CALM_FIRST   = 150;   // random items in this window run without gaps
  localparam int         CALM_LAST    = 249;
  localparam int         DRAIN_CYCLES = 100;   // longer than a full-list shift

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  plb_req_t in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  plb_rsp_t out_data;

  logic calm = 1'b0;  // suppresses idling on both channels
  int   list_fill;    // element count as the stimulus side tracks it
  int   error_total;
  int   outstanding;

  positional_list_buffer_top #(
    .DEPTH      (LIST_DEPTH),
    .ELEM_WIDTH (ELEM_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // watches both channels, predicts every response and counts failures
  plb_list_checker #(
    .DEPTH      (LIST_DEPTH),
    .ELEM_WIDTH (ELEM_BITS)
  ) list_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .error_total (error_total),
    .outstanding (outstanding)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure: low about 22 percent of the time, never in the calm window
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  function automatic plb_req_t req_item(input logic [1:0] kind, input int pos,
                                        input logic [WORD_W-1:0] value);
    plb_req_t item;
    item.req_type   = kind;
    item.position   = POS_W'(pos);
    item.elem_value = value;
    return item;
  endfunction

  // random request; grow biases toward inserts, otherwise toward removes
  function automatic plb_req_t random_item(input int fill, input bit grow);
    plb_req_t item;
    int       pick;
    int       span;
    item.elem_value = $urandom();
    pick = $urandom_range(99);
    if (pick < 3) begin
      item.req_type = REQ_UNUSED;
    end else if (pick < 25) begin
      item.req_type = REQ_READ;
    end else if (pick < (grow ? 88 : 40)) begin
      item.req_type = REQ_INSERT;
    end else begin
      item.req_type = REQ_REMOVE;
    end
    // legal positions run to count+1 for insert and to count otherwise
    span = (item.req_type == REQ_INSERT) ? fill + 1 : fill;
    pick = $urandom_range(99);
    if (span == 0 || pick < 8) begin
      item.position = POS_W'($urandom_range(127));  // mostly out of range noise
    end else if (pick < 30) begin
      item.position = POS_W'(1);                   // head of the list
    end else if (pick < 52) begin
      item.position = POS_W'(span);                // tail, or one past it for insert
    end else begin
      item.position = POS_W'($urandom_range(span, 1));
    end
    return item;
  endfunction

  // presents one item, holds it until taken, then updates the fill estimate
  task automatic send_item(input plb_req_t item);
    // random gap before the item; valid only drops when a gap really happens
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (item.req_type)
      REQ_INSERT: begin
        if (list_fill < LIST_DEPTH && item.position >= 1 && item.position <= list_fill + 1)
          list_fill++;
      end
      REQ_REMOVE: begin
        if (list_fill > 0 && item.position >= 1 && item.position <= list_fill)
          list_fill--;
      end
      default: ;
    endcase
  endtask

  initial begin
    int n;
    bit filling;
    list_fill = 0;
    filling   = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, bad positions, value extremes, head/middle/tail moves
    send_item(req_item(REQ_READ,   1,   '0));            // read on empty list
    send_item(req_item(REQ_REMOVE, 1,   '0));            // remove on empty list
    send_item(req_item(REQ_INSERT, 0,   32'h0000_0001)); // position zero
    send_item(req_item(REQ_INSERT, 2,   32'h0000_0002)); // past count+1
    send_item(req_item(REQ_INSERT, 1,   32'hFFFF_FFFF)); // all-ones word
    send_item(req_item(REQ_INSERT, 1,   32'h0000_0000)); // insert at head, zero word
    send_item(req_item(REQ_INSERT, 3,   32'hA5A5_5A5A)); // append at tail
    send_item(req_item(REQ_INSERT, 2,   32'h1234_5678)); // insert in the middle
    send_item(req_item(REQ_READ,   0,   '0));            // read position zero
    send_item(req_item(REQ_READ,   5,   '0));            // just past the count
    send_item(req_item(REQ_READ,   127, '0));            // widest position
    send_item(req_item(REQ_READ,   64,  '0));            // top position, list not full
    send_item(req_item(REQ_UNUSED, 1,   32'hDEAD_BEEF)); // spare request code
    for (n = 1; n <= 4; n++) send_item(req_item(REQ_READ, n, '0));
    send_item(req_item(REQ_REMOVE, 2,   '0));            // remove from the middle
    send_item(req_item(REQ_REMOVE, 3,   '0));            // remove the tail
    send_item(req_item(REQ_REMOVE, 1,   '0));            // remove the head
    send_item(req_item(REQ_READ,   1,   '0));
    send_item(req_item(REQ_INSERT, 127, 32'h5555_AAAA)); // insert far out of range
    send_item(req_item(REQ_REMOVE, 2,   '0));            // remove past the count
    send_item(req_item(REQ_REMOVE, 1,   '0));            // last element, list empties
    send_item(req_item(REQ_INSERT, 1,   $urandom()));

    // random: fill toward full, linger there, drain toward empty, and again
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= CALM_FIRST && n <= CALM_LAST);
      if (filling && list_fill == LIST_DEPTH && $urandom_range(3) == 0) begin
        filling = 1'b0;
      end else if (!filling && list_fill == 0 && $urandom_range(3) == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(99) < 2) begin
        filling = !filling;
      end
      send_item(random_item(list_fill, filling));
    end

    // last item is taken at this edge
    in_valid <= 1'b0;
    calm     <= 1'b0;
    // let the checker's count catch up with the last item before polling it
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, far beyond a slow correct run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
